// ===== hw/rtl/momentum_sgd_update_macros.svh =====
// Assertion macros used by the RTL that checks itself.
// Each macro expects clk and rst_n in scope.
`ifndef MOMENTUM_SGD_UPDATE_MACROS_SVH
`define MOMENTUM_SGD_UPDATE_MACROS_SVH

// Same-cycle implication
`define MSU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/msu_pkg.sv =====
package msu_pkg;

    // Entry store geometry (power of two, at most 2^IDX_W entries)
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = 10;

    localparam int DATA_W = 32;
    localparam int COEF_W = 24;
    localparam int FRAC_W = 24;
    localparam int PROD_W = DATA_W + COEF_W + 1;

    // Command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Regularization modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_L1    = 2'd1;
    localparam logic [1:0] MODE_L2    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_MOMENTUM   = 2'd1;
    localparam logic [1:0] REG_STEP_SCALE = 2'd2;
    localparam logic [1:0] REG_DECAY      = 2'd3;

    // Configuration reset values
    localparam logic [1:0]        MODE_RST       = MODE_PLAIN;
    localparam logic [COEF_W-1:0] MOMENTUM_RST   = 24'd14680064;
    localparam logic [COEF_W-1:0] STEP_SCALE_RST = 24'd16777;
    localparam logic [COEF_W-1:0] DECAY_RST      = 24'd0;

    // Signed 32-bit limits
    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    // Write request into the entry store
    typedef struct packed {
        logic                     en;
        logic [ADDR_W-1:0]        addr;
        logic signed [DATA_W-1:0] weight;
        logic signed [DATA_W-1:0] velocity;
    } msu_wr_t;

endpackage

// ===== hw/rtl/msu_store.sv =====
module msu_store
(
    input  logic                                   clk,
    input  logic                                   rd_en,
    input  logic [msu_pkg::ADDR_W-1:0]             rd_addr,
    output logic signed [msu_pkg::DATA_W-1:0]      rd_weight,
    output logic signed [msu_pkg::DATA_W-1:0]      rd_velocity,
    input  msu_pkg::msu_wr_t                       wr
);

    logic signed [msu_pkg::DATA_W-1:0] weight_mem   [msu_pkg::DEPTH];
    logic signed [msu_pkg::DATA_W-1:0] velocity_mem [msu_pkg::DEPTH];

    // Write both halves of an entry together
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            weight_mem[wr.addr]   <= wr.weight;
            velocity_mem[wr.addr] <= wr.velocity;
        end
    end

    // Registered read; hold data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_weight   <= weight_mem[rd_addr];
            rd_velocity <= velocity_mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/momentum_sgd_update.sv =====
// Momentum SGD update engine with optional L1 or L2 weight decay.
// Holds 1024 weight/velocity pairs in signed Q16.16 in an on-chip store.
// Requests: raise start with command, entry_index, load_value and gradient;
// the request is taken at a clock edge where start is high and busy is low.
// Commands: load writes a weight and clears its velocity, update applies a
// gradient (velocity*momentum + gradient*step_scale, then weight penalty),
// read reports an entry. Every request gives exactly one result.
// Results: done is high for one cycle with out_index, out_weight,
// out_velocity and saturated; the receiver cannot stall, so take it then.
// Each request passes through the store read, the multiply, the velocity sum and clamp,
// and weight forming with write-back; the result strobe follows write-back.
// A new request is taken only after the previous one leaves write-back, as set by the
// single read-modify-write pass over the store; busy covers multiply, sum and write-back.
// Configuration: cfg_write with cfg_index/cfg_data, only while idle.
// Reset: rst_n clears control and restores register defaults; store contents
// stay undefined until loaded, and no clearing pass is run.
`include "momentum_sgd_update_macros.svh"

module momentum_sgd_update
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_write,
    input  logic [1:0]                         cfg_index,
    input  logic [msu_pkg::COEF_W-1:0]         cfg_data,
    // request
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         command,
    input  logic [msu_pkg::IDX_W-1:0]          entry_index,
    input  logic signed [msu_pkg::DATA_W-1:0]  load_value,
    input  logic signed [msu_pkg::DATA_W-1:0]  gradient,
    // result
    output logic                               done,
    output logic [msu_pkg::IDX_W-1:0]          out_index,
    output logic signed [msu_pkg::DATA_W-1:0]  out_weight,
    output logic signed [msu_pkg::DATA_W-1:0]  out_velocity,
    output logic                               saturated
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_WB   = 2'd3;

    localparam int NV_W  = msu_pkg::DATA_W + 2;
    localparam int PEN_W = msu_pkg::DATA_W + 1;
    localparam int WS_W  = msu_pkg::DATA_W + 3;

    logic [1:0] state_reg, state_next;
    logic       done_reg;
    logic       accept;

    logic [1:0]                 mode_reg;
    logic [msu_pkg::COEF_W-1:0] momentum_reg;
    logic [msu_pkg::COEF_W-1:0] step_scale_reg;
    logic [msu_pkg::COEF_W-1:0] decay_reg;

    logic [1:0]                        cmd_reg;
    logic [msu_pkg::IDX_W-1:0]         index_reg;
    logic signed [msu_pkg::DATA_W-1:0] load_value_reg;
    logic signed [msu_pkg::DATA_W-1:0] gradient_reg;

    logic signed [msu_pkg::DATA_W-1:0] rd_weight;
    logic signed [msu_pkg::DATA_W-1:0] rd_velocity;
    msu_pkg::msu_wr_t                  wr;

    logic signed [msu_pkg::PROD_W-1:0] prod_v_reg, prod_g_reg, prod_w_reg;

    logic signed [NV_W-1:0]            nv_sum;
    logic signed [msu_pkg::DATA_W-1:0] nv_next, nv_reg;
    logic                              nv_sat_next, nv_sat_reg;
    logic signed [PEN_W-1:0]           pen_next, pen_reg;
    logic signed [PEN_W-1:0]           l1_mag;

    logic signed [WS_W-1:0]            w_sum;
    logic signed [msu_pkg::DATA_W-1:0] w_upd;
    logic                              w_sat;

    logic signed [msu_pkg::DATA_W-1:0] res_weight, res_velocity;
    logic                              res_sat;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;

    // Sequence one request through read, multiply, sum and write back
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_WB;
            ST_WB:   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_WB);
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= msu_pkg::MODE_RST;
            momentum_reg   <= msu_pkg::MOMENTUM_RST;
            step_scale_reg <= msu_pkg::STEP_SCALE_RST;
            decay_reg      <= msu_pkg::DECAY_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                msu_pkg::REG_MODE:       mode_reg       <= cfg_data[1:0];
                msu_pkg::REG_MOMENTUM:   momentum_reg   <= cfg_data;
                msu_pkg::REG_STEP_SCALE: step_scale_reg <= cfg_data;
                msu_pkg::REG_DECAY:      decay_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg        <= command;
            index_reg      <= entry_index;
            load_value_reg <= load_value;
            gradient_reg   <= gradient;
        end
    end

    msu_store u_store
    (
        .clk         (clk),
        .rd_en       (accept),
        .rd_addr     (entry_index[msu_pkg::ADDR_W-1:0]),
        .rd_weight   (rd_weight),
        .rd_velocity (rd_velocity),
        .wr          (wr)
    );

    // Multiply stage: three products, two against the stored entry and one on the gradient
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_v_reg <= rd_velocity * $signed({1'b0, momentum_reg});
            prod_g_reg <= gradient_reg * $signed({1'b0, step_scale_reg});
            prod_w_reg <= rd_weight * $signed({1'b0, decay_reg});
        end
    end

    // Sum stage: floor the products, clamp velocity, form the penalty
    assign nv_sum = NV_W'($signed(prod_v_reg[msu_pkg::PROD_W-1:msu_pkg::FRAC_W]))
                  + NV_W'($signed(prod_g_reg[msu_pkg::PROD_W-1:msu_pkg::FRAC_W]));
    assign l1_mag = $signed({{(PEN_W-16){1'b0}}, decay_reg[msu_pkg::COEF_W-1:8]});

    always_comb
    begin
        nv_sat_next = 1'b0;
        nv_next     = nv_sum[msu_pkg::DATA_W-1:0];
        if (nv_sum > NV_W'(msu_pkg::S32_MAX))
        begin
            nv_sat_next = 1'b1;
            nv_next     = msu_pkg::S32_MAX;
        end
        else if (nv_sum < NV_W'(msu_pkg::S32_MIN))
        begin
            nv_sat_next = 1'b1;
            nv_next     = msu_pkg::S32_MIN;
        end

        unique case (mode_reg)
            msu_pkg::MODE_L1: pen_next = (rd_weight > 0) ? l1_mag : -l1_mag;
            msu_pkg::MODE_L2: pen_next = prod_w_reg[msu_pkg::PROD_W-1:msu_pkg::FRAC_W];
            default:          pen_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SUM)
        begin
            nv_reg     <= nv_next;
            nv_sat_reg <= nv_sat_next;
            pen_reg    <= pen_next;
        end
    end

    // Write-back stage: new weight with clamp, then pick the result
    assign w_sum = WS_W'(rd_weight) - WS_W'(nv_reg) - WS_W'(pen_reg);

    always_comb
    begin
        w_sat = 1'b0;
        w_upd = w_sum[msu_pkg::DATA_W-1:0];
        if (w_sum > WS_W'(msu_pkg::S32_MAX))
        begin
            w_sat = 1'b1;
            w_upd = msu_pkg::S32_MAX;
        end
        else if (w_sum < WS_W'(msu_pkg::S32_MIN))
        begin
            w_sat = 1'b1;
            w_upd = msu_pkg::S32_MIN;
        end

        unique case (cmd_reg)
            msu_pkg::CMD_LOAD:
            begin
                res_weight   = load_value_reg;
                res_velocity = '0;
                res_sat      = 1'b0;
            end
            msu_pkg::CMD_UPDATE:
            begin
                res_weight   = w_upd;
                res_velocity = nv_reg;
                res_sat      = nv_sat_reg | w_sat;
            end
            default:
            begin
                res_weight   = rd_weight;
                res_velocity = rd_velocity;
                res_sat      = 1'b0;
            end
        endcase

        wr.en       = (state_reg == ST_WB) &&
                      ((cmd_reg == msu_pkg::CMD_LOAD) || (cmd_reg == msu_pkg::CMD_UPDATE));
        wr.addr     = index_reg[msu_pkg::ADDR_W-1:0];
        wr.weight   = res_weight;
        wr.velocity = res_velocity;
    end

    // Hold the result for its strobe cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WB)
        begin
            out_index    <= index_reg;
            out_weight   <= res_weight;
            out_velocity <= res_velocity;
            saturated    <= res_sat;
        end
    end

    `MSU_ASSERT_NEXT(a_accept_busy, accept, busy && (state_reg == ST_MUL), "accepted request did not start")
    `MSU_ASSERT_NEXT(a_wb_done, state_reg == ST_WB, done && !busy, "write-back gave no result strobe")
    `MSU_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")
    `MSU_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `MSU_ASSERT_SAME(a_write_wb, wr.en, state_reg == ST_WB, "store written outside write-back")

endmodule

// ===== tb/sv/momentum_sgd_update_tb.sv =====
`timescale 1ns / 100ps

module momentum_sgd_update_tb;

    localparam int RESULT_LATENCY = 4;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_COUNT    = 7;
    localparam int PHASE_ITEMS    = 262;

    // Spare codes with no name in the package
    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [msu_pkg::IDX_W-1:0]         index;
        logic signed [msu_pkg::DATA_W-1:0] weight;
        logic signed [msu_pkg::DATA_W-1:0] velocity;
        logic                              sat;
    } entry_report_t;

    // Mirror of the weight/velocity table and its coefficients
    class momentum_mirror;
        logic signed [msu_pkg::DATA_W-1:0] weights    [msu_pkg::DEPTH];
        logic signed [msu_pkg::DATA_W-1:0] velocities [msu_pkg::DEPTH];
        logic [1:0]                        mode;
        int                                momentum_coef;
        int                                step_coef;
        int                                decay_coef;
        entry_report_t                     owed[$];
        int                                errors;

        function new();
            mode          = msu_pkg::MODE_RST;
            momentum_coef = msu_pkg::MOMENTUM_RST;
            step_coef     = msu_pkg::STEP_SCALE_RST;
            decay_coef    = msu_pkg::DECAY_RST;
            errors        = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [msu_pkg::COEF_W-1:0] data);
            case (index)
                msu_pkg::REG_MODE:       mode = data[1:0];
                msu_pkg::REG_MOMENTUM:   momentum_coef = data;
                msu_pkg::REG_STEP_SCALE: step_coef = data;
                msu_pkg::REG_DECAY:      decay_coef = data;
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("%0t: mismatch: %s", $time, msg);
            errors++;
        endtask

        function longint clamp_s32(longint x, inout bit hit);
            if (x > longint'(msu_pkg::S32_MAX)) begin
                hit = 1'b1;
                return longint'(msu_pkg::S32_MAX);
            end
            if (x < longint'(msu_pkg::S32_MIN)) begin
                hit = 1'b1;
                return longint'(msu_pkg::S32_MIN);
            end
            return x;
        endfunction

        // Apply one accepted request to the table and queue the entry it reports
        function void apply_request(logic [1:0] cmd, logic [msu_pkg::IDX_W-1:0] idx,
                                    logic signed [msu_pkg::DATA_W-1:0] load_v,
                                    logic signed [msu_pkg::DATA_W-1:0] grad);
            longint        w;
            longint        v;
            longint        g;
            longint        penalty;
            bit            hit;
            int            slot;
            entry_report_t r;
            slot = int'(idx) % msu_pkg::DEPTH;
            w    = weights[slot];
            v    = velocities[slot];
            hit  = 1'b0;
            if (cmd == msu_pkg::CMD_LOAD) begin
                w = load_v;
                v = 0;
            end
            else if (cmd == msu_pkg::CMD_UPDATE) begin
                g = grad;
                // Truncating products: arithmetic shift floors toward minus infinity
                v = ((v * momentum_coef) >>> msu_pkg::FRAC_W)
                  + ((g * step_coef) >>> msu_pkg::FRAC_W);
                v = clamp_s32(v, hit);
                penalty = 0;
                if (mode == msu_pkg::MODE_L1)
                    penalty = (w > 0) ? longint'(decay_coef >> 8) : -longint'(decay_coef >> 8);
                else if (mode == msu_pkg::MODE_L2)
                    penalty = (w * decay_coef) >>> msu_pkg::FRAC_W;
                w = clamp_s32(w - v - penalty, hit);
            end
            weights[slot]    = w[msu_pkg::DATA_W-1:0];
            velocities[slot] = v[msu_pkg::DATA_W-1:0];
            r.index    = idx;
            r.weight   = w[msu_pkg::DATA_W-1:0];
            r.velocity = v[msu_pkg::DATA_W-1:0];
            r.sat      = hit;
            owed.push_back(r);
        endfunction

        // Compare one reported entry with the oldest one owed
        task match_result(logic [msu_pkg::IDX_W-1:0] idx,
                          logic signed [msu_pkg::DATA_W-1:0] w,
                          logic signed [msu_pkg::DATA_W-1:0] v, logic sat);
            entry_report_t r;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("result for entry %0d with nothing owed", idx));
                return;
            end
            r = owed.pop_front();
            if (idx !== r.index)
                report_mismatch($sformatf("out_index %0d, want %0d", idx, r.index));
            if (w !== r.weight)
                report_mismatch($sformatf("entry %0d out_weight %h, want %h",
                                          r.index, w, r.weight));
            if (v !== r.velocity)
                report_mismatch($sformatf("entry %0d out_velocity %h, want %h",
                                          r.index, v, r.velocity));
            if (sat !== r.sat)
                report_mismatch($sformatf("entry %0d saturated %b, want %b",
                                          r.index, sat, r.sat));
        endtask
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_write;
    logic [1:0]                        cfg_index;
    logic [msu_pkg::COEF_W-1:0]        cfg_data;
    logic                              start;
    logic                              busy;
    logic [1:0]                        command;
    logic [msu_pkg::IDX_W-1:0]         entry_index;
    logic signed [msu_pkg::DATA_W-1:0] load_value;
    logic signed [msu_pkg::DATA_W-1:0] gradient;
    logic                              done;
    logic [msu_pkg::IDX_W-1:0]         out_index;
    logic signed [msu_pkg::DATA_W-1:0] out_weight;
    logic signed [msu_pkg::DATA_W-1:0] out_velocity;
    logic                              saturated;

    momentum_mirror            mirror;
    logic [msu_pkg::IDX_W-1:0] loaded_entries[$];
    int                        burst_left;
    int                        cycle_count;

    momentum_sgd_update dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .entry_index  (entry_index),
        .load_value   (load_value),
        .gradient     (gradient),
        .done         (done),
        .out_index    (out_index),
        .out_weight   (out_weight),
        .out_velocity (out_velocity),
        .saturated    (saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check every result strobe against the mirror
    always @(posedge clk)
    begin
        if (rst_n && done)
            mirror.match_result(out_index, out_weight, out_velocity, saturated);
    end

    // End the run if it hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Present a request and hold it until the block takes it
    task automatic issue_request(logic [1:0] cmd, logic [msu_pkg::IDX_W-1:0] idx,
                                 logic signed [msu_pkg::DATA_W-1:0] load_v,
                                 logic signed [msu_pkg::DATA_W-1:0] grad);
        command     = cmd;
        entry_index = idx;
        load_value  = load_v;
        gradient    = grad;
        start       = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mirror.apply_request(cmd, idx, load_v, grad);
        if (cmd == msu_pkg::CMD_LOAD)
            loaded_entries.push_back(idx);
        @(negedge clk);
    endtask

    // Drop start and let every owed result come back
    task automatic wait_idle();
        start = 1'b0;
        while (mirror.owed.size() != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY) @(negedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [msu_pkg::COEF_W-1:0] data);
        wait_idle();
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        mirror.set_register(index, data);
    endtask

    // Mix of edge values, full-range noise and modest Q16.16 magnitudes
    function automatic logic signed [msu_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return 0;
                    1: return -1;
                    2: return 1;
                    3: return msu_pkg::S32_MAX;
                    default: return msu_pkg::S32_MIN;
                endcase
            end
            1, 2: return $urandom;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    task automatic configure_phase(int phase);
        logic [1:0]                 mode;
        logic [msu_pkg::COEF_W-1:0] mom;
        logic [msu_pkg::COEF_W-1:0] step;
        logic [msu_pkg::COEF_W-1:0] dec;
        mode = 2'($urandom_range(0, 3));
        mom  = msu_pkg::COEF_W'($urandom_range(0, 24'hFF_FFFF));
        step = msu_pkg::COEF_W'($urandom_range(0, 24'hFF_FFFF));
        dec  = msu_pkg::COEF_W'($urandom_range(0, 24'hFF_FFFF));
        case (phase)
            1:
            begin
                mode = msu_pkg::MODE_L1;
                mom  = 24'd15099494;
                step = 24'd65536;
                dec  = 24'hFF_FFFF;
            end
            2:
            begin
                mode = msu_pkg::MODE_L2;
                mom  = 24'hFF_FFFF;
                step = 24'hFF_FFFF;
                dec  = 24'hFF_FFFF;
            end
            3:
            begin
                mode = MODE_SPARE;
                mom  = 24'd0;
                step = 24'hFF_FFFF;
            end
            4:
            begin
                mode = msu_pkg::MODE_L1;
                dec  = 24'd0;
            end
            5:
            begin
                mode = msu_pkg::MODE_L2;
                step = 24'd0;
            end
            7:
            begin
                mode = msu_pkg::MODE_PLAIN;
                mom  = 24'hFF_FFFF;
                step = 24'd1;
                dec  = 24'hFF_FFFF;
            end
            default: ;
        endcase
        write_register(msu_pkg::REG_MODE, msu_pkg::COEF_W'(mode));
        write_register(msu_pkg::REG_MOMENTUM, mom);
        write_register(msu_pkg::REG_STEP_SCALE, step);
        write_register(msu_pkg::REG_DECAY, dec);
    endtask

    // Random requests in bursts; updates and reads only touch loaded entries
    task automatic run_random(int count);
        int                        pick;
        int                        gap_len;
        int                        n;
        logic [1:0]                cmd;
        logic [msu_pkg::IDX_W-1:0] idx;
        for (int k = 0; k < count; k++)
        begin
            if (burst_left == 0)
            begin
                gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap_len > 0)
                begin
                    start = 1'b0;
                    repeat (gap_len) @(negedge clk);
                end
                burst_left = $urandom_range(1, 30);
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            n    = loaded_entries.size();
            if (n == 0 || pick < 15)
            begin
                cmd = msu_pkg::CMD_LOAD;
                idx = msu_pkg::IDX_W'($urandom_range(0, msu_pkg::DEPTH - 1));
            end
            else
            begin
                if (pick < 78)
                    cmd = msu_pkg::CMD_UPDATE;
                else if (pick < 93)
                    cmd = msu_pkg::CMD_READ;
                else
                    cmd = CMD_SPARE;
                // Favor recently loaded entries so velocities build up
                if ($urandom_range(0, 9) < 6)
                    idx = loaded_entries[n - 1 - $urandom_range(0, (n > 8) ? 7 : n - 1)];
                else
                    idx = loaded_entries[$urandom_range(0, n - 1)];
            end
            issue_request(cmd, idx, pick_value(), pick_value());
        end
        start = 1'b0;
    endtask

    initial
    begin
        mirror      = new();
        burst_left  = 0;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = msu_pkg::REG_MODE;
        cfg_data    = '0;
        start       = 1'b0;
        command     = msu_pkg::CMD_READ;
        entry_index = '0;
        load_value  = '0;
        gradient    = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Edge weights, spare command code, weight clamping at both ends
        issue_request(msu_pkg::CMD_LOAD, 10'd0, msu_pkg::S32_MAX, 32'sd12345);
        issue_request(msu_pkg::CMD_LOAD, 10'd1023, msu_pkg::S32_MIN, 32'sd0);
        issue_request(msu_pkg::CMD_LOAD, 10'd5, 32'sd0, msu_pkg::S32_MIN);
        issue_request(msu_pkg::CMD_LOAD, 10'h2AA, 32'sd1, -32'sd1);
        issue_request(msu_pkg::CMD_READ, 10'd0, 32'sd0, 32'sd0);
        issue_request(CMD_SPARE, 10'd1023, -32'sd1, msu_pkg::S32_MAX);
        issue_request(msu_pkg::CMD_UPDATE, 10'd0, 32'sd0, msu_pkg::S32_MIN);
        issue_request(msu_pkg::CMD_UPDATE, 10'd1023, 32'sd0, msu_pkg::S32_MAX);
        issue_request(msu_pkg::CMD_UPDATE, 10'd5, msu_pkg::S32_MAX, 32'sd0);
        issue_request(msu_pkg::CMD_UPDATE, 10'd5, 32'sd0, -32'sd1);
        issue_request(msu_pkg::CMD_UPDATE, 10'h2AA, 32'sd0, 32'sd1);
        issue_request(msu_pkg::CMD_READ, 10'h2AA, 32'sd0, 32'sd0);

        // Full coefficients: drive the velocity into its clamp
        write_register(msu_pkg::REG_MOMENTUM, 24'hFF_FFFF);
        write_register(msu_pkg::REG_STEP_SCALE, 24'hFF_FFFF);
        issue_request(msu_pkg::CMD_LOAD, 10'd7, 32'sd0, 32'sd0);
        issue_request(msu_pkg::CMD_UPDATE, 10'd7, 32'sd0, msu_pkg::S32_MIN);
        issue_request(msu_pkg::CMD_UPDATE, 10'd7, 32'sd0, msu_pkg::S32_MIN);
        issue_request(msu_pkg::CMD_UPDATE, 10'd7, 32'sd0, msu_pkg::S32_MAX);

        // Sign penalty: a zero weight counts as negative
        write_register(msu_pkg::REG_MODE, msu_pkg::COEF_W'(msu_pkg::MODE_L1));
        write_register(msu_pkg::REG_DECAY, 24'hFF_FFFF);
        issue_request(msu_pkg::CMD_LOAD, 10'd9, 32'sd0, 32'sd0);
        issue_request(msu_pkg::CMD_UPDATE, 10'd9, 32'sd0, 32'sd0);
        issue_request(msu_pkg::CMD_UPDATE, 10'd9, 32'sd0, 32'sd0);

        // Weight penalty on the old weight at both extremes
        write_register(msu_pkg::REG_MODE, msu_pkg::COEF_W'(msu_pkg::MODE_L2));
        issue_request(msu_pkg::CMD_LOAD, 10'd9, msu_pkg::S32_MIN, 32'sd0);
        issue_request(msu_pkg::CMD_UPDATE, 10'd9, 32'sd0, 32'sd0);
        issue_request(msu_pkg::CMD_UPDATE, 10'd0, 32'sd0, 32'sd0);

        for (int phase = 1; phase <= PHASE_COUNT; phase++)
        begin
            configure_phase(phase);
            run_random(PHASE_ITEMS);
        end

        // Drain and give stray strobes a chance to show up
        wait_idle();
        repeat (2 * RESULT_LATENCY) @(posedge clk);
        if (mirror.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
